// File: hw/rtl/sls_pkg.sv
`default_nettype none
package sls_pkg;

    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 32;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int OUT_CNT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE   = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [VAL_W-1:0]  key;
        logic        [CNT_W-1:0]  count;
    } t_row_ctrl;

    typedef struct packed {
        logic signed [VAL_W-1:0]  head;
        logic                     found;
    } t_row_stat;

endpackage
`default_nettype wire

// File: hw/rtl/sls_stream_if.sv
`default_nettype none
interface sls_req_if import sls_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

interface sls_rsp_if import sls_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] element;
    logic [OUT_CNT_W-1:0]    count;
    logic                    last;

    modport source (output valid, output status, output element, output count,
                    output last, input ready);
    modport sink (input valid, input status, input element, input count,
                  input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sls_cell.sv
`default_nettype none
module sls_cell import sls_pkg::*; (
    input  wire logic                    i_clk,
    input  wire t_row_ctrl               i_ctrl,
    input  wire logic                    i_valid,
    input  wire logic                    i_tail,
    input  wire logic signed [VAL_W-1:0] i_left_val,
    input  wire logic signed [VAL_W-1:0] i_right_val,
    input  wire logic signed [VAL_W-1:0] i_head_val,
    input  wire logic                    i_left_lt,
    input  wire logic                    i_left_seen,
    output logic signed [VAL_W-1:0]      o_val,
    output logic                         o_lt,
    output logic                         o_seen
);

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;
    logic                    eq;

    assign o_lt   = i_valid && (r_val < i_ctrl.key);
    assign eq     = i_valid && (r_val == i_ctrl.key);
    assign o_seen = i_left_seen || eq;
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (o_lt) begin
                    n_val = r_val;
                end else if (i_left_lt) begin
                    n_val = i_ctrl.key;
                end else begin
                    n_val = i_left_val;
                end
            end
            OP_REMOVE: begin
                if (o_seen) begin
                    n_val = i_right_val;
                end
            end
            OP_ROTATE: begin
                n_val = i_tail ? i_head_val : i_right_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
`default_nettype wire

// File: hw/rtl/sls_cell_row.sv
`default_nettype none
module sls_cell_row import sls_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_row_ctrl i_ctrl,
    output t_row_stat      o_stat
);

    logic signed [VAL_W-1:0] cell_val [CAPACITY];
    logic signed [VAL_W-1:0] left_val [CAPACITY];
    logic signed [VAL_W-1:0] right_val [CAPACITY];
    logic                    lt_chain [CAPACITY+1];
    logic                    seen_chain [CAPACITY+1];

    assign lt_chain[0]   = 1'b1;
    assign seen_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_val[i] = '0;
        end else begin : g_inner_left
            assign left_val[i] = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_final
            assign right_val[i] = cell_val[i];
        end else begin : g_inner_right
            assign right_val[i] = cell_val[i+1];
        end

        sls_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (i_ctrl),
            .i_valid     (CNT_W'(i) < i_ctrl.count),
            .i_tail      (CNT_W'(i + 1) == i_ctrl.count),
            .i_left_val  (left_val[i]),
            .i_right_val (right_val[i]),
            .i_head_val  (cell_val[0]),
            .i_left_lt   (lt_chain[i]),
            .i_left_seen (seen_chain[i]),
            .o_val       (cell_val[i]),
            .o_lt        (lt_chain[i+1]),
            .o_seen      (seen_chain[i+1])
        );
    end

    assign o_stat.head  = cell_val[0];
    assign o_stat.found = seen_chain[CAPACITY];

endmodule
`default_nettype wire

// File: hw/rtl/sorted_list_store.sv
// Ordered store of up to CAPACITY signed values held in a row of cells, one value per
// cell, kept in ascending order with duplicates allowed. Insert, remove and lookup
// compare the request against every cell at once; insert and remove shift the row by
// one place in the same cycle, and each such transaction gives one response.
// List-all of n values first takes the request, then the row rotates by one cell per
// cycle while the response register is free, and the head cell is sent out, which
// leaves the order as it was when the last value is gone; no request is taken during
// that time, and a stalled response holds the rotation. An empty list gives one
// response with status empty. The response register lets a new request in while the
// previous response is taken in the same cycle.
`default_nettype none
module sorted_list_store import sls_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sls_req_if.sink    i_req,
    sls_rsp_if.source  o_rsp
);

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        r_list_idx;
    logic [CNT_W-1:0]        n_list_idx;
    logic                    r_out_valid;
    t_status                 r_out_status;
    t_status                 n_out_status;
    logic signed [VAL_W-1:0] r_out_element;
    logic signed [VAL_W-1:0] n_out_element;
    logic [OUT_CNT_W-1:0]    r_out_count;
    logic [OUT_CNT_W-1:0]    n_out_count;
    logic                    r_out_last;
    logic                    n_out_last;
    logic                    load_out;
    logic                    out_free;
    logic                    take;
    logic                    list_end;
    t_cmd                    cmd;
    t_row_ctrl               row_ctrl;
    t_row_stat               row_stat;

    assign cmd         = t_cmd'(i_req.command);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign take        = i_req.valid && i_req.ready;
    assign list_end    = (r_list_idx == r_count - CNT_W'(1));

    sls_cell_row u_row (
        .i_clk  (i_clk),
        .i_ctrl (row_ctrl),
        .o_stat (row_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && cmd == CMD_LIST && r_count != '0) begin
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                if (out_free && list_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        row_ctrl.op    = OP_HOLD;
        row_ctrl.key   = i_req.value;
        row_ctrl.count = r_count;
        n_count        = r_count;
        n_list_idx     = r_list_idx;
        load_out       = 1'b0;
        n_out_status   = STAT_DONE;
        n_out_element  = i_req.value;
        n_out_count    = OUT_CNT_W'(r_count);
        n_out_last     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                n_list_idx = '0;
                if (take) begin
                    load_out = 1'b1;
                    unique case (cmd)
                        CMD_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                row_ctrl.op = OP_INSERT;
                                n_count     = r_count + CNT_W'(1);
                                n_out_count = OUT_CNT_W'(n_count);
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_out_status = STAT_EMPTY;
                            end else if (row_stat.found) begin
                                row_ctrl.op = OP_REMOVE;
                                n_count     = r_count - CNT_W'(1);
                                n_out_count = OUT_CNT_W'(n_count);
                            end else begin
                                n_out_status = STAT_ABSENT;
                            end
                        end
                        CMD_LOOKUP: begin
                            n_out_status = row_stat.found ? STAT_DONE : STAT_ABSENT;
                        end
                        CMD_LIST: begin
                            if (r_count == '0) begin
                                n_out_status  = STAT_EMPTY;
                                n_out_element = '0;
                            end else begin
                                load_out = 1'b0;
                            end
                        end
                        default: begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (out_free) begin
                    row_ctrl.op   = OP_ROTATE;
                    load_out      = 1'b1;
                    n_out_element = row_stat.head;
                    n_out_last    = list_end;
                    n_list_idx    = r_list_idx + CNT_W'(1);
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_list_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_list_idx <= n_list_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status  <= n_out_status;
            r_out_element <= n_out_element;
            r_out_count   <= n_out_count;
            r_out_last    <= n_out_last;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_out_status;
    assign o_rsp.element = r_out_element;
    assign o_rsp.count   = r_out_count;
    assign o_rsp.last    = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Stored count exceeds capacity.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && cmd == CMD_INSERT && r_count != CNT_W'(CAPACITY))
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("Accepted insert did not grow the count by one.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STAT_FULL)
        |-> r_out_count == OUT_CNT_W'(CAPACITY))
        else $error("Full response with a count below capacity.");

    a_list_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST && out_free && list_end) |=> r_state == S_IDLE)
        else $error("Listing did not finish after its final transaction.");

endmodule
`default_nettype wire

// File: tb/sv/sls_tb_pkg.sv
package sls_tb_pkg;
    import sls_pkg::*;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  element;
        logic [OUT_CNT_W-1:0]     count;
        logic                     last;
    } t_store_response;

    // The class keeps its own copy of the sorted store. It also keeps the queue of
    // responses that the accepted requests are due to produce.
    class sorted_store_checker;
        logic signed [VAL_W-1:0] held_values[$];
        t_store_response         expected_responses[$];
        int unsigned             mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int unsigned held_count();
            return held_values.size();
        endfunction

        function int unsigned outstanding();
            return expected_responses.size();
        endfunction

        function logic signed [VAL_W-1:0] any_held();
            return held_values[$urandom_range(held_values.size() - 1)];
        endfunction

        function void add_expected(t_status st, logic signed [VAL_W-1:0] el,
                                   int unsigned n, logic lst);
            t_store_response r;
            r.status  = st;
            r.element = el;
            r.count   = OUT_CNT_W'(n);
            r.last    = lst;
            expected_responses.push_back(r);
        endfunction

        function void note_request(t_cmd cmd, logic signed [VAL_W-1:0] v);
            int unsigned n;
            int unsigned pos;
            n = held_values.size();
            pos = 0;
            case (cmd)
                CMD_INSERT: begin
                    if (n >= CAPACITY) begin
                        add_expected(STAT_FULL, v, n, 1'b1);
                    end else begin
                        while (pos < n && held_values[pos] < v) pos++;
                        held_values.insert(pos, v);
                        add_expected(STAT_DONE, v, n + 1, 1'b1);
                    end
                end
                CMD_REMOVE: begin
                    if (n == 0) begin
                        add_expected(STAT_EMPTY, v, 0, 1'b1);
                    end else begin
                        while (pos < n && held_values[pos] != v) pos++;
                        if (pos == n) begin
                            add_expected(STAT_ABSENT, v, n, 1'b1);
                        end else begin
                            held_values.delete(pos);
                            add_expected(STAT_DONE, v, n - 1, 1'b1);
                        end
                    end
                end
                CMD_LOOKUP: begin
                    while (pos < n && held_values[pos] != v) pos++;
                    add_expected((pos < n) ? STAT_DONE : STAT_ABSENT, v, n, 1'b1);
                end
                default: begin
                    if (n == 0) begin
                        add_expected(STAT_EMPTY, '0, 0, 1'b1);
                    end else begin
                        for (int unsigned i = 0; i < n; i++) begin
                            add_expected(STAT_DONE, held_values[i], n, i + 1 == n);
                        end
                    end
                end
            endcase
        endfunction

        function void check_response(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] el,
                                     logic [OUT_CNT_W-1:0] cnt, logic lst);
            t_store_response want;
            if (expected_responses.size() == 0) begin
                $error("unexpected response: status %0d element %0d count %0d last %0d",
                       st, el, cnt, lst);
                mismatches++;
                return;
            end
            want = expected_responses.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                mismatches++;
            end
            if (el !== want.element) begin
                $error("element: expected %0d, actual %0d", want.element, el);
                mismatches++;
            end
            if (cnt !== want.count) begin
                $error("count: expected %0d, actual %0d", want.count, cnt);
                mismatches++;
            end
            if (lst !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, lst);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// File: tb/sv/sorted_list_store_tb.sv
module sorted_list_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sls_pkg::*;
    import sls_tb_pkg::*;

    localparam int RANDOM_ITEMS = 410;
    localparam int CYCLE_LIMIT  = 300000;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    logic clk;
    logic rst_n;
    logic steady;
    int   cycles;

    sorted_store_checker sb;

    sls_req_if req ();
    sls_rsp_if rsp ();

    sorted_list_store dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        rsp.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp.ready <= steady || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge clk) begin
        if (rst_n && req.valid && req.ready) begin
            sb.note_request(t_cmd'(req.command), req.value);
        end
        if (rst_n && rsp.valid && rsp.ready) begin
            sb.check_response(rsp.status, rsp.element, rsp.count, rsp.last);
        end
    end

    task automatic send_request(t_cmd cmd, logic signed [VAL_W-1:0] v);
        while (!steady && $urandom_range(99) < 18) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.command <= cmd;
        req.value   <= v;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic send_random(ref logic grow);
        t_cmd                    cmd;
        logic signed [VAL_W-1:0] v;
        int unsigned             roll;
        if (sb.held_count() == CAPACITY) grow = 1'b0;
        if (sb.held_count() == 0) grow = 1'b1;
        if ($urandom_range(99) < 2) grow = ~grow;
        roll = $urandom_range(99);
        if (roll < 8) begin
            cmd = CMD_LIST;
        end else if (roll < 26) begin
            cmd = CMD_LOOKUP;
        end else if (grow) begin
            cmd = (roll < 76) ? CMD_INSERT : CMD_REMOVE;
        end else begin
            cmd = (roll < 44) ? CMD_INSERT : CMD_REMOVE;
        end
        roll = $urandom_range(99);
        if (roll < 40 && sb.held_count() != 0) begin
            v = sb.any_held();
        end else if (roll < 70) begin
            v = $signed($urandom_range(7)) - 4;
        end else if (roll < 85) begin
            case ($urandom_range(3))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = VAL_MIN + 1;
                default: v = VAL_MAX - 1;
            endcase
        end else begin
            v = $urandom;
        end
        send_request(cmd, v);
    endtask

    initial begin
        logic grow;
        sb = new();
        steady = 1'b0;
        grow = 1'b1;
        rst_n       <= 1'b0;
        req.valid   <= 1'b0;
        req.command <= CMD_INSERT;
        req.value   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_LIST, 32'sd9);
        send_request(CMD_REMOVE, 32'sd5);
        send_request(CMD_LOOKUP, 32'sd5);
        send_request(CMD_INSERT, VAL_MAX);
        send_request(CMD_INSERT, VAL_MIN);
        send_request(CMD_INSERT, 32'sd0);
        send_request(CMD_INSERT, -32'sd1);
        send_request(CMD_INSERT, 32'sd0);
        send_request(CMD_LOOKUP, 32'sd0);
        send_request(CMD_LOOKUP, 32'sd1);
        send_request(CMD_REMOVE, 32'sd7);
        send_request(CMD_LIST, 32'sd0);
        send_request(CMD_REMOVE, 32'sd0);
        while (sb.held_count() < CAPACITY) begin
            send_request(CMD_INSERT, $urandom);
        end
        send_request(CMD_INSERT, 32'sd3);
        send_request(CMD_LIST, -32'sd1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 160 && i < 260);
            send_random(grow);
        end
        steady = 1'b0;
        req.valid <= 1'b0;

        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            if (sb.outstanding() != 0) begin
                $error("%0d expected responses never arrived", sb.outstanding());
            end
            $display("Verification failed");
        end
        $finish;
    end

endmodule
